### design/mdv_pkg.sv
// Shared types, constants and the LFO sine table for the modulated delay vibrato.
// No dependencies; every other file in the design imports this package.
package mdv_pkg;

    localparam int DELAY_DEPTH     = 512;
    localparam int SINE_TABLE_SIZE = 256;
    localparam int SAMPLE_BITS     = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int ADDR_W     = $clog2(DELAY_DEPTH);
    localparam int CNT_W      = $clog2(DELAY_DEPTH + 1);
    localparam int SINE_IDX_W = $clog2(SINE_TABLE_SIZE);
    localparam int SINE_W     = 16;
    localparam int FRAC_W     = 15;
    localparam int DEPTH_W    = 8;
    localparam int PHASE_W    = 32;
    localparam int TAP_W      = DEPTH_W + SINE_W + 2;
    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH      = CFG_INDEX_W'(1);

    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = PHASE_W'(68178);
    localparam logic [DEPTH_W-1:0] DEPTH_RESET      = DEPTH_W'(88);

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_TABLE_SIZE];

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [ADDR_W-1:0]             tap_int;
        logic [FRAC_W-1:0]             tap_frac;
    } mdv_cmd_t;

    // Quarter-wave degree-9 Taylor series in Q30, scaled to Q1.15 and rounded.
    function automatic sine_tab_t sine_build();
        sine_tab_t   tab;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        logic [1:0]  quad;
        for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
            p    = (64'(k) << 32) / SINE_TABLE_SIZE;
            quad = p[31:30];
            r    = {34'd0, p[29:0]};
            if (quad[0]) begin
                r = Q30_ONE - r;
            end
            x  = (r * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            t  = Q30_ONE - x2 / 64'd72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
            t  = (x * t) >> 30;
            v  = (t * 64'd32767 + (Q30_ONE >> 1)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[k] = quad[1] ? -SINE_W'(v) : SINE_W'(v);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = sine_build();

endpackage

### design/mdv_front.sv
// Front end: accepts input words, steps the LFO phase and works out the tap delay.
// Depends on mdv_pkg; feeds commands into mdv_queue.
module mdv_front import mdv_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [PHASE_W-1:0]            phase_step,
    input  logic [DEPTH_W-1:0]            depth_samples,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_in_sample,
    output logic                          cmd_valid,
    input  logic                          cmd_full,
    output mdv_cmd_t                      cmd
);

    logic [PHASE_W-1:0]            phase_reg;
    logic                          hold_valid_reg;
    logic signed [SAMPLE_BITS-1:0] hold_sample_reg;
    logic signed [SINE_W-1:0]      hold_sine_reg;

    logic                          accept;
    logic                          push;
    logic [DEPTH_W:0]              depth_p1;
    logic signed [DEPTH_W+SINE_W:0] tap_mod;
    logic signed [TAP_W-1:0]       tap;

    assign push    = hold_valid_reg && !cmd_full;
    assign s_ready = !hold_valid_reg || push;
    assign accept  = s_valid && s_ready;

    assign depth_p1 = {1'b0, depth_samples} + (DEPTH_W+1)'(1);
    assign tap_mod  = $signed({1'b0, depth_samples}) * hold_sine_reg;
    assign tap      = $signed({(TAP_W-DEPTH_W-1-FRAC_W)'(0), depth_p1, FRAC_W'(0)})
                    + TAP_W'(tap_mod);

    assign cmd_valid    = hold_valid_reg;
    assign cmd.sample   = hold_sample_reg;
    assign cmd.tap_int  = tap[FRAC_W +: ADDR_W];
    assign cmd.tap_frac = tap[FRAC_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_reg + phase_step;
                hold_valid_reg <= 1'b1;
            end else if (push) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_sample_reg <= s_in_sample;
            hold_sine_reg   <= SINE_TAB[phase_reg[PHASE_W-1 -: SINE_IDX_W]];
        end
    end

endmodule

### design/mdv_queue.sv
// Short command queue between the front end and the delay-line sequencer.
// Depends on mdv_pkg for the command type and queue depth.
module mdv_queue import mdv_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  mdv_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     pop_valid,
    output mdv_cmd_t pop_cmd
);

    mdv_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    logic do_push;
    logic do_pop;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### design/mdv_back.sv
// Back end: circular delay memory, two-tap read, interpolation and output register.
// Depends on mdv_pkg; takes commands from mdv_queue.
module mdv_back import mdv_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    input  mdv_cmd_t                      cmd,
    output logic                          cmd_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_sample
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RDA  = 5'b00010,
        ST_RDB  = 5'b00100,
        ST_MULB = 5'b01000,
        ST_SUM  = 5'b10000
    } back_state_t;

    localparam int PA_W  = SAMPLE_BITS + FRAC_W + 1;
    localparam int PB_W  = SAMPLE_BITS + FRAC_W + 2;
    localparam int ACC_W = PB_W + 1;
    localparam int Y_W   = ACC_W - FRAC_W;

    localparam logic signed [Y_W-1:0] SMAX = Y_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Y_W-1:0] SMIN = -SMAX - Y_W'(1);

    logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

    back_state_t                   state_reg;
    back_state_t                   state_next;
    logic [ADDR_W-1:0]             wp_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [ADDR_W-1:0]             a_addr_reg;
    logic [FRAC_W-1:0]             tf_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          rd_ok_reg;
    logic signed [PA_W-1:0]        prod_a_reg;
    logic signed [PB_W-1:0]        prod_b_reg;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;

    logic                          mem_we;
    logic                          rd_en;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          rd_hit;
    logic signed [SAMPLE_BITS-1:0] tap_val;
    logic [FRAC_W:0]               weight_b;
    logic signed [ACC_W-1:0]       acc;
    logic signed [Y_W-1:0]         y;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          out_load;

    assign mem_we   = (state_reg == ST_IDLE) && cmd_valid;
    assign cmd_pop  = mem_we;
    assign rd_en    = (state_reg == ST_RDA) || (state_reg == ST_RDB);
    assign rd_addr  = (state_reg == ST_RDB) ? a_addr_reg + ADDR_W'(1) : a_addr_reg;
    assign rd_hit   = (cnt_reg == CNT_W'(DELAY_DEPTH)) || (CNT_W'(rd_addr) < cnt_reg);
    assign tap_val  = rd_ok_reg ? rd_data_reg : '0;
    assign weight_b = (FRAC_W+1)'(2 ** FRAC_W) - {1'b0, tf_reg};
    assign out_load = (state_reg == ST_SUM) && (!m_valid_reg || m_ready);

    assign acc = ACC_W'(prod_a_reg) + ACC_W'(prod_b_reg)
               + ACC_W'(2 ** (FRAC_W - 1));
    assign y   = Y_W'(acc >>> FRAC_W);

    always_comb begin
        priority if (y > SMAX) begin
            y_sat = SAMPLE_BITS'(SMAX);
        end else if (y < SMIN) begin
            y_sat = SAMPLE_BITS'(SMIN);
        end else begin
            y_sat = SAMPLE_BITS'(y);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    state_next = ST_RDA;
                end
            end
            ST_RDA:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_MULB;
            ST_MULB: state_next = ST_SUM;
            ST_SUM: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mem_we) begin
                wp_reg <= (wp_reg == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp_reg + ADDR_W'(1);
                if (cnt_reg != CNT_W'(DELAY_DEPTH)) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= cmd.sample;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_ok_reg   <= rd_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            a_addr_reg <= wp_reg - cmd.tap_int;
            tf_reg     <= cmd.tap_frac;
        end
        if (state_reg == ST_RDB) begin
            prod_a_reg <= tap_val * $signed({1'b0, tf_reg});
        end
        if (state_reg == ST_MULB) begin
            prod_b_reg <= tap_val * $signed({1'b0, weight_b});
        end
        if (out_load) begin
            m_sample_reg <= y_sat;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_sample_reg;

endmodule

### design/modulated_delay_vibrato_core.sv
// Top level of the modulated delay vibrato: configuration registers and the
// front end, command queue and back end. Depends on mdv_pkg and the mdv_* modules.
//
// Usage. Audio words in signed Q1.15 enter on the s_ channel (s_valid, s_ready,
// s_in_sample) and one interpolated, saturated word leaves on the m_ channel
// (m_valid, m_ready, m_out_sample) for every word taken. The configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the LFO phase
// step at index 0 and the modulation depth in samples at index 1; it is always
// ready, and should be written only while the block is idle.
// An accepted word passes through the front-stage register, the command queue, the
// back-end sequencer and the output register. The sequencer takes a new command only
// once the last is done: it writes the delay memory, reads its two taps through a
// single read port, and forms two weighted products and their sum.
// The front end takes a new word while the back end is busy, as long as the
// two-entry command queue has room. If the receiver stalls, the finished word
// waits in the output register, the back end holds its next result, and
// s_ready falls once the queue and the front stage are full.
// Reset zeroes the LFO phase and write pointer and loads the default phase
// step and depth; the delay memory reads as zero until each entry is written.
module modulated_delay_vibrato_core import mdv_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_in_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_sample,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    logic [PHASE_W-1:0] phase_step_reg;
    logic [DEPTH_W-1:0] depth_reg;

    logic     cmd_valid;
    logic     q_full;
    mdv_cmd_t front_cmd;
    logic     q_valid;
    logic     q_pop;
    mdv_cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= PHASE_STEP_RESET;
            depth_reg      <= DEPTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_PHASE_STEP) begin
                phase_step_reg <= cfg_data[PHASE_W-1:0];
            end
            if (cfg_index == CFG_DEPTH) begin
                depth_reg <= cfg_data[DEPTH_W-1:0];
            end
        end
    end

    mdv_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .phase_step    (phase_step_reg),
        .depth_samples (depth_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_sample   (s_in_sample),
        .cmd_valid     (cmd_valid),
        .cmd_full      (q_full),
        .cmd           (front_cmd)
    );

    mdv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_valid),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    mdv_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (q_valid),
        .cmd          (q_cmd),
        .cmd_pop      (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample)
    );

endmodule

### bench/mdv_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the modulated delay vibrato: it watches the s_, m_ and cfg_ channels, predicts
// every output word from its own delay line, LFO and sine table, and counts mismatches.
// Depends on mdv_pkg for widths and register indexes; instantiated by tb beside the block.
module mdv_checker import mdv_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_in_sample,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [SAMPLE_BITS-1:0] m_out_sample,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output int                            errors,
    output int                            pending,
    output int                            words_in,
    output int                            words_out
);

    localparam logic [63:0] Q30_UNIT         = 64'd1 << 30;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint      SAMPLE_MAX       = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint      SAMPLE_MIN       = -SAMPLE_MAX - 1;
    localparam longint      FRAC_ONE         = longint'(1) << FRAC_W;
    localparam int          MAX_REPORTS      = 10;

    logic signed [SAMPLE_BITS-1:0] sine_rom [SINE_TABLE_SIZE];
    logic signed [SAMPLE_BITS-1:0] delay_mem [DELAY_DEPTH];
    logic [ADDR_W-1:0]             wr_ptr;
    logic [PHASE_W-1:0]            lfo_phase;
    logic [PHASE_W-1:0]            phase_step;
    logic [DEPTH_W-1:0]            depth;
    logic signed [SAMPLE_BITS-1:0] expected_words [$];
    int                            mismatches;
    int                            n_in;
    int                            n_out;

    // Odd Taylor series to the ninth power on the quarter wave, evaluated in Q30.
    function automatic logic signed [SAMPLE_BITS-1:0] lfo_sine(input int k);
        logic [63:0] ph;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] mag;
        logic [1:0]  quarter;
        ph      = (64'(k) << 32) / SINE_TABLE_SIZE;
        quarter = ph[31:30];
        r       = {34'd0, ph[29:0]};
        if (quarter[0]) begin
            r = Q30_UNIT - r;
        end
        x  = (r * QUARTER_TURN_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_UNIT;
        for (int n = 4; n >= 1; n--) begin
            t = Q30_UNIT - ((x2 * t) >> 30) / 64'((2 * n) * (2 * n + 1));
        end
        t   = (x * t) >> 30;
        mag = (t * 64'd32767 + (Q30_UNIT >> 1)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return quarter[1] ? -SAMPLE_BITS'(mag) : SAMPLE_BITS'(mag);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] vibrato_word(
        input logic signed [SAMPLE_BITS-1:0] w
    );
        logic signed [SAMPLE_BITS-1:0] sv;
        logic signed [63:0]            tap;
        logic signed [63:0]            acc;
        logic signed [63:0]            y;
        logic [ADDR_W-1:0]             tap_int;
        logic [FRAC_W-1:0]             tap_frac;
        logic [ADDR_W-1:0]             cur;
        logic [ADDR_W-1:0]             far_addr;
        logic [ADDR_W-1:0]             near_addr;
        sv        = sine_rom[lfo_phase[PHASE_W-1 -: SINE_IDX_W]];
        lfo_phase = lfo_phase + phase_step;
        tap       = (longint'(depth) + 1) * FRAC_ONE + longint'(depth) * longint'(sv);
        tap_int   = tap[FRAC_W +: ADDR_W];
        tap_frac  = tap[FRAC_W-1:0];
        cur            = wr_ptr;
        delay_mem[cur] = w;
        wr_ptr         = cur + 1'b1;
        far_addr  = cur - tap_int;
        near_addr = far_addr + 1'b1;
        acc = longint'(delay_mem[far_addr]) * longint'(tap_frac)
            + longint'(delay_mem[near_addr]) * (FRAC_ONE - longint'(tap_frac));
        y = (acc + (FRAC_ONE >>> 1)) >>> FRAC_W;
        if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
        end
        if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
        end
        return SAMPLE_BITS'(y);
    endfunction

    initial begin
        for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
            sine_rom[k] = lfo_sine(k);
        end
    end

    always @(posedge aclk) begin
        logic signed [SAMPLE_BITS-1:0] want;
        if (!aresetn) begin
            for (int k = 0; k < DELAY_DEPTH; k++) begin
                delay_mem[k] = '0;
            end
            wr_ptr     = '0;
            lfo_phase  = '0;
            phase_step = PHASE_STEP_RESET;
            depth      = DEPTH_RESET;
            expected_words.delete();
            mismatches = 0;
            n_in       = 0;
            n_out      = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PHASE_STEP) begin
                    phase_step = cfg_data[PHASE_W-1:0];
                end else if (cfg_index == CFG_DEPTH) begin
                    depth = cfg_data[DEPTH_W-1:0];
                end
            end
            if (m_valid && m_ready) begin
                n_out++;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: output word %0d (%0d) arrived with none expected",
                                 $time, n_out, m_out_sample);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (m_out_sample !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: out_sample of word %0d: expected %0d, got %0d",
                                     $time, n_out, want, m_out_sample);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                n_in++;
                expected_words.push_back(vibrato_word(s_in_sample));
            end
        end
        errors    <= mismatches;
        pending   <= expected_words.size();
        words_in  <= n_in;
        words_out <= n_out;
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Top of the vibrato testbench: clock, reset, register writes and audio words with random
// idling and back-pressure. Depends on mdv_pkg, mdv_checker and modulated_delay_vibrato_core.
module tb import mdv_pkg::*; ();

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int IDLE_PCT        = 37;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 100;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CALM_PHASE      = 3;
    localparam int HOLD_PHASE      = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_INDEX_W'(14);

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_in_sample = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_out_sample;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index   = '0;
    logic [CFG_DATA_W-1:0]         cfg_data    = '0;

    int   errors;
    int   pending;
    int   words_in;
    int   words_out;
    int   cycles   = 0;
    int   settings = 0;
    logic calm     = 1'b0;
    logic hold_req = 1'b0;

    modulated_delay_vibrato_core dut (.*);

    mdv_checker u_checker (.*);

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        bit held;
        held = 1'b0;
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            @(posedge aclk);
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] opening_word(input int k);
        case (k)
            0, 7, 8, 13, 18: return 16'sh7FFF;
            1, 9, 10, 12, 19: return 16'sh8000;
            3, 14:  return -16'sd1;
            4:      return 16'sd1;
            5:      return 16'sh5555;
            6:      return 16'shAAAA;
            11:     return 16'sd12345;
            16:     return 16'sd16384;
            17:     return -16'sd16384;
            20:     return 16'sd255;
            21:     return -16'sd256;
            22:     return 16'sh00FF;
            23:     return 16'sh7F00;
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end
        if (roll < 20) begin
            return SAMPLE_BITS'($urandom_range(400) - 200);
        end
        return SAMPLE_BITS'($urandom);
    endfunction

    task automatic send_word(input logic signed [SAMPLE_BITS-1:0] w);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_sample <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] step_word,
                             input logic [CFG_DATA_W-1:0] depth_word);
        write_reg(CFG_PHASE_STEP, step_word);
        write_reg(CFG_DEPTH, depth_word);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] step_word;
        logic [CFG_DATA_W-1:0] depth_word;
        logic [DEPTH_W-1:0]    depth_pick;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < 12; k++) begin
            send_word(opening_word(k));
        end
        wait_idle();
        configure('0, '0);
        for (int k = 12; k < 18; k++) begin
            send_word(opening_word(k));
        end
        wait_idle();
        write_reg(CFG_SPARE, $urandom);
        configure(32'h8000_0000, 32'hA5A5_5AFF);
        for (int k = 18; k < 24; k++) begin
            send_word(opening_word(k));
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p % 4)
                0:       step_word = $urandom;
                1:       step_word = $urandom_range(1 << 22, 1 << 16);
                2:       step_word = $urandom_range(1 << 28, 1 << 24);
                default: step_word = $urandom_range(1) ? 32'h8000_0000 : 32'd1;
            endcase
            if (p == 0) begin
                depth_pick = '1;
            end else if (p == 1) begin
                depth_pick = '0;
            end else begin
                depth_pick = DEPTH_W'($urandom_range(255));
            end
            depth_word                = $urandom;
            depth_word[DEPTH_W-1:0]   = depth_pick;
            configure(step_word, depth_word);
            calm = (p == CALM_PHASE);
            for (int w = 0; w < WORDS_PER_PHASE; w++) begin
                if (p == HOLD_PHASE && w == 20) begin
                    hold_req = 1'b1;
                end
                send_word(pick_sample());
            end
        end
        calm = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d audio words and took %0d back across %0d register settings,",
                 words_in, words_out, settings);
        $display("with zero and full depth, extreme phase steps, a long hold-off and no-idle run.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
design/mdv_pkg.sv
design/mdv_front.sv
design/mdv_queue.sv
design/mdv_back.sv
design/modulated_delay_vibrato_core.sv
bench/mdv_checker.sv
bench/tb.sv
